FILE: hdl/ucts_pkg.sv
// ----------------------------------------------------------------------------
// ucts_pkg
// Types, codes and constants of the USB control transfer sequencer.
// ----------------------------------------------------------------------------
package ucts_pkg;

    localparam int FRAME_BITS = 16;
    localparam int STAMP_W    = (FRAME_BITS < 16) ? FRAME_BITS : 16;
    localparam int CMP_W      = (FRAME_BITS > 16) ? FRAME_BITS : 16;

    typedef enum logic [3:0] {
        ST_SETUP           = 4'd0,
        ST_SETUP_WAIT      = 4'd1,
        ST_DATA_IN         = 4'd2,
        ST_DATA_IN_WAIT    = 4'd3,
        ST_DATA_OUT        = 4'd4,
        ST_DATA_OUT_WAIT   = 4'd5,
        ST_STATUS_IN       = 4'd6,
        ST_STATUS_IN_WAIT  = 4'd7,
        ST_STATUS_OUT      = 4'd8,
        ST_STATUS_OUT_WAIT = 4'd9,
        ST_ERROR           = 4'd10,
        ST_STALLED         = 4'd11,
        ST_COMPLETE        = 4'd12
    } t_state;

    localparam logic [2:0] CHS_IDLE     = 3'd0;
    localparam logic [2:0] CHS_DONE     = 3'd1;
    localparam logic [2:0] CHS_NOTREADY = 3'd2;
    localparam logic [2:0] CHS_ERROR    = 3'd3;
    localparam logic [2:0] CHS_STALL    = 3'd4;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_SETUP     = 3'd1;
    localparam logic [2:0] ACT_DATA_IN   = 3'd2;
    localparam logic [2:0] ACT_DATA_OUT  = 3'd3;
    localparam logic [2:0] ACT_ZLP_IN    = 3'd4;
    localparam logic [2:0] ACT_ZLP_OUT   = 3'd5;

    localparam logic [1:0] TGL_KEEP   = 2'd0;
    localparam logic [1:0] TGL_ONE    = 2'd1;
    localparam logic [1:0] TGL_INVERT = 2'd2;

    localparam logic [1:0] CS_PROGRESS = 2'd0;
    localparam logic [1:0] CS_XACT_ERR = 2'd1;
    localparam logic [1:0] CS_STALL    = 2'd2;
    localparam logic [1:0] CS_FAIL     = 2'd3;

    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_NOTSUPP = 2'd1;
    localparam logic [1:0] RES_FAIL    = 2'd2;

    localparam logic [2:0] CFG_DATA_TO   = 3'd0;
    localparam logic [2:0] CFG_NODATA_TO = 3'd1;
    localparam logic [2:0] CFG_MAX_ERR   = 3'd2;
    localparam logic [2:0] CFG_IN_CH     = 3'd3;
    localparam logic [2:0] CFG_OUT_CH    = 3'd4;

    typedef struct packed {
        logic [15:0] data_to;
        logic [15:0] nodata_to;
        logic [7:0]  max_err;
        logic [3:0]  in_ch;
        logic [3:0]  out_ch;
    } t_cfg;

    typedef struct packed {
        logic        command;
        logic [63:0] setup_packet;
        logic [15:0] transfer_length;
        logic [2:0]  chan_status;
        logic [15:0] frame_now;
    } t_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  action_channel;
        logic [15:0] action_length;
        logic [63:0] setup_bytes;
        logic [1:0]  toggle_op;
        logic        restore_host_state;
        logic [1:0]  ctrl_status;
        logic [1:0]  step_result;
        logic [3:0]  ctrl_state;
    } t_result;

endpackage

FILE: hdl/ucts_in_if.sv
// ----------------------------------------------------------------------------
// ucts_in_if
// Command channel: start and poll items for the sequencer.
// ----------------------------------------------------------------------------
interface ucts_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] setup_packet;
    logic [15:0] transfer_length;
    logic [2:0]  chan_status;
    logic [15:0] frame_now;

    modport source (
        output valid, command, setup_packet, transfer_length, chan_status, frame_now,
        input  ready
    );
    modport sink (
        input  valid, command, setup_packet, transfer_length, chan_status, frame_now,
        output ready
    );
endinterface

FILE: hdl/ucts_out_if.sv
// ----------------------------------------------------------------------------
// ucts_out_if
// Result channel: one step result per item.
// ----------------------------------------------------------------------------
interface ucts_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [3:0]  action_channel;
    logic [15:0] action_length;
    logic [63:0] setup_bytes;
    logic [1:0]  toggle_op;
    logic        restore_host_state;
    logic [1:0]  ctrl_status;
    logic [1:0]  step_result;
    logic [3:0]  ctrl_state;

    modport source (
        output valid, action, action_channel, action_length, setup_bytes, toggle_op,
               restore_host_state, ctrl_status, step_result, ctrl_state,
        input  ready
    );
    modport sink (
        input  valid, action, action_channel, action_length, setup_bytes, toggle_op,
               restore_host_state, ctrl_status, step_result, ctrl_state,
        output ready
    );
endinterface

FILE: hdl/ucts_cfg_regs.sv
// ----------------------------------------------------------------------------
// ucts_cfg_regs
// Configuration register file: timeouts, retry limit and channel numbers.
// ----------------------------------------------------------------------------
module ucts_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [2:0]        i_idx,
    input  logic [15:0]       i_data,
    output ucts_pkg::t_cfg    o_cfg
);

    ucts_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_to   <= 16'd5000;
            r_cfg.nodata_to <= 16'd50;
            r_cfg.max_err   <= 8'd2;
            r_cfg.in_ch     <= 4'd1;
            r_cfg.out_ch    <= 4'd0;
        end else if (i_we) begin
            case (i_idx)
                ucts_pkg::CFG_DATA_TO:   r_cfg.data_to   <= i_data;
                ucts_pkg::CFG_NODATA_TO: r_cfg.nodata_to <= i_data;
                ucts_pkg::CFG_MAX_ERR:   r_cfg.max_err   <= i_data[7:0];
                ucts_pkg::CFG_IN_CH:     r_cfg.in_ch     <= i_data[3:0];
                ucts_pkg::CFG_OUT_CH:    r_cfg.out_ch    <= i_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/ucts_seq.sv
// ----------------------------------------------------------------------------
// ucts_seq
// Transfer state and combinational step logic: next state and step result.
// ----------------------------------------------------------------------------
module ucts_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  ucts_pkg::t_item     i_item,
    input  ucts_pkg::t_cfg      i_cfg,
    output ucts_pkg::t_result   o_res
);

    ucts_pkg::t_state               r_state,   n_state;
    logic [63:0]                    r_setup,   n_setup;
    logic [15:0]                    r_len,     n_len;
    logic [7:0]                     r_retry,   n_retry;
    logic [ucts_pkg::STAMP_W-1:0]   r_stamp,   n_stamp;
    logic [15:0]                    r_timeout, n_timeout;

    logic [ucts_pkg::FRAME_BITS-1:0] frame_diff;
    logic                            timed_out;
    logic [7:0]                      retry_inc;

    assign frame_diff = ucts_pkg::FRAME_BITS'(i_item.frame_now)
                      - ucts_pkg::FRAME_BITS'(r_stamp);
    assign timed_out  = ucts_pkg::CMP_W'(frame_diff) > ucts_pkg::CMP_W'(r_timeout);
    assign retry_inc  = (r_retry != 8'hFF) ? (r_retry + 8'd1) : r_retry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ucts_pkg::ST_SETUP;
            r_setup   <= '0;
            r_len     <= '0;
            r_retry   <= '0;
            r_stamp   <= '0;
            r_timeout <= '0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_setup   <= n_setup;
            r_len     <= n_len;
            r_retry   <= n_retry;
            r_stamp   <= n_stamp;
            r_timeout <= n_timeout;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_setup   = r_setup;
        n_len     = r_len;
        n_retry   = r_retry;
        n_stamp   = r_stamp;
        n_timeout = r_timeout;
        o_res     = '0;

        if (i_item.command) begin
            n_setup = i_item.setup_packet;
            n_len   = i_item.transfer_length;
            n_retry = '0;
            n_state = ucts_pkg::ST_SETUP;
        end else begin
            case (r_state)
                ucts_pkg::ST_SETUP: begin
                    o_res.action         = ucts_pkg::ACT_SETUP;
                    o_res.action_channel = i_cfg.out_ch;
                    o_res.setup_bytes    = r_setup;
                    n_state              = ucts_pkg::ST_SETUP_WAIT;
                end
                ucts_pkg::ST_SETUP_WAIT: begin
                    if (i_item.chan_status == ucts_pkg::CHS_DONE) begin
                        if (r_setup[63:48] != 16'd0) begin
                            n_timeout = i_cfg.data_to;
                            n_state   = r_setup[7] ? ucts_pkg::ST_DATA_IN
                                                   : ucts_pkg::ST_DATA_OUT;
                        end else begin
                            n_timeout = i_cfg.nodata_to;
                            n_state   = r_setup[7] ? ucts_pkg::ST_STATUS_OUT
                                                   : ucts_pkg::ST_STATUS_IN;
                        end
                        n_stamp = ucts_pkg::STAMP_W'(i_item.frame_now);
                    end else if (i_item.chan_status == ucts_pkg::CHS_ERROR) begin
                        n_state           = ucts_pkg::ST_ERROR;
                        o_res.ctrl_status = ucts_pkg::CS_XACT_ERR;
                    end
                end
                ucts_pkg::ST_DATA_IN: begin
                    o_res.action         = ucts_pkg::ACT_DATA_IN;
                    o_res.action_channel = i_cfg.in_ch;
                    o_res.action_length  = r_len;
                    n_state              = ucts_pkg::ST_DATA_IN_WAIT;
                end
                ucts_pkg::ST_DATA_IN_WAIT: begin
                    if (i_item.chan_status == ucts_pkg::CHS_DONE) begin
                        n_state = ucts_pkg::ST_STATUS_OUT;
                    end else if (i_item.chan_status == ucts_pkg::CHS_STALL) begin
                        o_res.restore_host_state = 1'b1;
                    end else if (i_item.chan_status == ucts_pkg::CHS_ERROR || timed_out) begin
                        n_state = ucts_pkg::ST_ERROR;
                    end
                end
                ucts_pkg::ST_DATA_OUT: begin
                    o_res.action         = ucts_pkg::ACT_DATA_OUT;
                    o_res.action_channel = i_cfg.out_ch;
                    o_res.action_length  = r_len;
                    o_res.toggle_op      = ucts_pkg::TGL_ONE;
                    n_state              = ucts_pkg::ST_DATA_OUT_WAIT;
                end
                ucts_pkg::ST_DATA_OUT_WAIT: begin
                    case (i_item.chan_status)
                        ucts_pkg::CHS_DONE:     n_state = ucts_pkg::ST_STATUS_IN;
                        ucts_pkg::CHS_STALL: begin
                            o_res.restore_host_state = 1'b1;
                            n_state                  = ucts_pkg::ST_STALLED;
                        end
                        ucts_pkg::CHS_NOTREADY: n_state = ucts_pkg::ST_DATA_OUT;
                        ucts_pkg::CHS_ERROR:    n_state = ucts_pkg::ST_ERROR;
                        default: ;
                    endcase
                end
                ucts_pkg::ST_STATUS_IN: begin
                    o_res.action         = ucts_pkg::ACT_ZLP_IN;
                    o_res.action_channel = i_cfg.in_ch;
                    n_state              = ucts_pkg::ST_STATUS_IN_WAIT;
                end
                ucts_pkg::ST_STATUS_IN_WAIT: begin
                    if (i_item.chan_status == ucts_pkg::CHS_DONE) begin
                        o_res.restore_host_state = 1'b1;
                        n_state                  = ucts_pkg::ST_COMPLETE;
                    end else if (i_item.chan_status == ucts_pkg::CHS_ERROR || timed_out) begin
                        n_state = ucts_pkg::ST_ERROR;
                    end else if (i_item.chan_status == ucts_pkg::CHS_STALL) begin
                        o_res.restore_host_state = 1'b1;
                        o_res.ctrl_status        = ucts_pkg::CS_STALL;
                        o_res.step_result        = ucts_pkg::RES_NOTSUPP;
                    end
                end
                ucts_pkg::ST_STATUS_OUT: begin
                    o_res.action         = ucts_pkg::ACT_ZLP_OUT;
                    o_res.action_channel = i_cfg.out_ch;
                    o_res.toggle_op      = ucts_pkg::TGL_INVERT;
                    n_state              = ucts_pkg::ST_STATUS_OUT_WAIT;
                end
                ucts_pkg::ST_STATUS_OUT_WAIT: begin
                    case (i_item.chan_status)
                        ucts_pkg::CHS_DONE: begin
                            o_res.restore_host_state = 1'b1;
                            n_state                  = ucts_pkg::ST_COMPLETE;
                        end
                        ucts_pkg::CHS_NOTREADY: n_state = ucts_pkg::ST_STATUS_OUT;
                        ucts_pkg::CHS_ERROR:    n_state = ucts_pkg::ST_ERROR;
                        default: ;
                    endcase
                end
                ucts_pkg::ST_ERROR: begin
                    n_retry = retry_inc;
                    if (retry_inc <= i_cfg.max_err) begin
                        n_state = ucts_pkg::ST_SETUP;
                    end else begin
                        o_res.ctrl_status        = ucts_pkg::CS_FAIL;
                        o_res.restore_host_state = 1'b1;
                        o_res.step_result        = ucts_pkg::RES_FAIL;
                    end
                end
                default: ;
            endcase
        end

        o_res.ctrl_state = n_state;
    end

endmodule

FILE: hdl/usb_control_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// usb_control_transfer_sequencer_core
// Host-side USB control transfer sequencer: setup, data and status stages.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  i_in     | in  | valid/ready       | command, setup_packet, transfer_length,
//           |     |                   | chan_status, frame_now
//  o_out    | out | valid/ready       | action, channel, length, setup_bytes,
//           |     |                   | toggle, restore, status, result, state
//  i_cfg_*  | in  | write enable only | index 0..4, 16-bit data
//
// A new item can enter while the last one waits in the result register. Items pass the
// input register, then step logic into the result register. State updates as an item
// leaves the input register. Synchronous active-low reset; no clearing pass.
// A stalled result holds the result register; the input register still fills if empty.
// ----------------------------------------------------------------------------
module usb_control_transfer_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ucts_in_if.sink     i_in,
    ucts_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    ucts_pkg::t_cfg    cfg;
    ucts_pkg::t_item   r_item;
    ucts_pkg::t_result step_res;
    ucts_pkg::t_result r_res;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    ucts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ucts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.command         <= i_in.command;
            r_item.setup_packet    <= i_in.setup_packet;
            r_item.transfer_length <= i_in.transfer_length;
            r_item.chan_status     <= i_in.chan_status;
            r_item.frame_now       <= i_in.frame_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.action             = r_res.action;
    assign o_out.action_channel     = r_res.action_channel;
    assign o_out.action_length      = r_res.action_length;
    assign o_out.setup_bytes        = r_res.setup_bytes;
    assign o_out.toggle_op          = r_res.toggle_op;
    assign o_out.restore_host_state = r_res.restore_host_state;
    assign o_out.ctrl_status        = r_res.ctrl_status;
    assign o_out.step_result        = r_res.step_result;
    assign o_out.ctrl_state         = r_res.ctrl_state;

`ifndef ASSERT_OFF
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("queued item lost while result side stalled");

    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_in_valid)
        else $error("accepted transfer not held in input register");

    a_step_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out.valid)
        else $error("step taken without a result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");
`endif

endmodule
